// File: rtl/core/nflf_pkg.sv
// Shared types, constants and reset values for the noise floor level follower.
package nflf_pkg;

  localparam int unsigned WordW        = 16;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned MsW          = 8;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned DecW         = WordW + MsW;
  localparam int unsigned DivCntW      = $clog2(WordW);
  localparam int unsigned WindowDepthDef = 16;

  localparam logic [CmdW-1:0] CMD_TRACK     = 2'd0;
  localparam logic [CmdW-1:0] CMD_CALIBRATE = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FLOOR_FACTOR   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FLOOR_MARGIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FLOOR_LOWEST   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FLOOR_HIGHEST  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FULL_SCALE     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_PER_MS = 3'd5;

  localparam logic [WordW-1:0] FLOOR_FACTOR_RST   = 16'd256;
  localparam logic [WordW-1:0] FLOOR_MARGIN_RST   = 16'd64;
  localparam logic [WordW-1:0] FLOOR_LOWEST_RST   = 16'd128;
  localparam logic [WordW-1:0] FLOOR_HIGHEST_RST  = 16'd8192;
  localparam logic [WordW-1:0] FULL_SCALE_RST     = 16'd32767;
  localparam logic [WordW-1:0] RELEASE_PER_MS_RST = 16'd131;

  localparam logic [WordW-1:0] LEVEL_MAX = 16'hFFFF;

  typedef struct packed {
    logic [WordW-1:0] floor_factor;
    logic [WordW-1:0] floor_margin;
    logic [WordW-1:0] floor_lowest;
    logic [WordW-1:0] floor_highest;
    logic [WordW-1:0] full_scale;
    logic [WordW-1:0] release_per_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load_floor;
    logic prep;
    logic div_step;
    logic env_step;
    logic clear;
    logic scan_step;
    logic mul;
    logic floor_upd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_cal;
    logic will_full;
    logic div_last;
    logic scan_last;
  } dp_status_t;

endpackage

// File: rtl/core/noise_floor_level_follower.sv
// Top level of the noise floor level follower: config registers, controller and datapath.
// Each track or calibrate word is accepted, loaded and prepared, then passes through the
// restoring divider for the normalized level and through the envelope update.
// A calibrate word with a full window then scans the window memory through its single
// read port and goes on to the floor multiply and clamp. A clear word is accepted and
// loaded and then goes straight to hand-over. Every word ends by handing over the result
// word, and that hand-over waits while the output register still holds an earlier word
// that is stalled.
// A new word is taken while the previous result word still waits at the output register.
module noise_floor_level_follower #(
  parameter int unsigned WINDOW_DEPTH = nflf_pkg::WindowDepthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [nflf_pkg::CmdW-1:0]     cmd,
  input  logic [nflf_pkg::WordW-1:0]    rms_sample,
  input  logic [nflf_pkg::MsW-1:0]      elapsed_ms,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [nflf_pkg::WordW-1:0]    level_out,
  output logic [nflf_pkg::WordW-1:0]    floor_out,
  output logic                          floor_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nflf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [nflf_pkg::WordW-1:0]    cfg_data
);
  import nflf_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd_ctl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  nflf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  nflf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd_ctl      (cmd_ctl)
  );

  nflf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_ctl     (cmd_ctl),
    .status      (status),
    .cmd         (cmd),
    .rms_sample  (rms_sample),
    .elapsed_ms  (elapsed_ms),
    .level_out   (level_out),
    .floor_out   (floor_out),
    .floor_ready (floor_ready)
  );

endmodule

// File: rtl/core/nflf_cfg.sv
// Configuration register file for the noise floor level follower.
module nflf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [nflf_pkg::CfgIdxW-1:0] wr_index,
  input  logic [nflf_pkg::WordW-1:0]   wr_data,
  output nflf_pkg::cfg_t              cfg
);
  import nflf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_factor   <= FLOOR_FACTOR_RST;
      cfg.floor_margin   <= FLOOR_MARGIN_RST;
      cfg.floor_lowest   <= FLOOR_LOWEST_RST;
      cfg.floor_highest  <= FLOOR_HIGHEST_RST;
      cfg.full_scale     <= FULL_SCALE_RST;
      cfg.release_per_ms <= RELEASE_PER_MS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FLOOR_FACTOR:   cfg.floor_factor   <= wr_data;
        REG_FLOOR_MARGIN:   cfg.floor_margin   <= wr_data;
        REG_FLOOR_LOWEST:   cfg.floor_lowest   <= wr_data;
        REG_FLOOR_HIGHEST:  cfg.floor_highest  <= wr_data;
        REG_FULL_SCALE:     cfg.full_scale     <= wr_data;
        REG_RELEASE_PER_MS: cfg.release_per_ms <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/nflf_datapath.sv
// Datapath: level divider, envelope, calibration window and floor computation.
module nflf_datapath #(
  parameter int unsigned WINDOW_DEPTH = nflf_pkg::WindowDepthDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nflf_pkg::cfg_t             cfg,
  input  nflf_pkg::dp_cmd_t          cmd_ctl,
  output nflf_pkg::dp_status_t       status,
  input  logic [nflf_pkg::CmdW-1:0]  cmd,
  input  logic [nflf_pkg::WordW-1:0] rms_sample,
  input  logic [nflf_pkg::MsW-1:0]   elapsed_ms,
  output logic [nflf_pkg::WordW-1:0] level_out,
  output logic [nflf_pkg::WordW-1:0] floor_out,
  output logic                       floor_ready
);
  import nflf_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(WINDOW_DEPTH);

  logic [CmdW-1:0]    cmd_r;
  logic [WordW-1:0]   rms_r;
  logic [MsW-1:0]     ms_r;
  logic [WordW-1:0]   fl;
  logic               tgt_zero;
  logic               tgt_sat;
  logic [WordW-1:0]   rem;
  logic [WordW-1:0]   quo;
  logic [WordW-1:0]   den;
  logic [DivCntW-1:0] div_cnt;
  logic [WordW-1:0]   envelope_level;
  logic [WordW-1:0]   floor_level;
  logic [IdxW-1:0]    write_index;
  logic               window_full;
  logic [WordW-1:0]   window_store [WINDOW_DEPTH];
  logic [WordW-1:0]   rd_data;
  logic               rd_vld;
  logic [CntW-1:0]    scan_cnt;
  logic [WordW-1:0]   win_min;
  logic [2*WordW-1:0] prod;

  logic [WordW-1:0]   fl_next;
  logic [WordW-1:0]   diff;
  logic [2*WordW-1:0] num;
  logic [WordW-1:0]   den_next;
  logic [WordW:0]     rem_shift;
  logic               rem_ge;
  logic [WordW-1:0]   tgt;
  logic [DecW-1:0]    dec;
  logic [WordW-1:0]   envelope_next;
  logic [WordW+8:0]   floor_sum;
  logic [WordW-1:0]   floor_next;

  always_comb begin
    if (floor_level < cfg.floor_lowest) begin
      fl_next = cfg.floor_lowest;
    end else if (floor_level > cfg.floor_highest) begin
      fl_next = cfg.floor_highest;
    end else begin
      fl_next = floor_level;
    end
  end

  assign diff     = rms_r - fl;
  assign num      = {diff, {WordW{1'b0}}} - {{WordW{1'b0}}, diff};
  assign den_next = cfg.full_scale - fl;

  assign rem_shift = {rem, quo[WordW-1]};
  assign rem_ge    = rem_shift >= {1'b0, den};

  always_comb begin
    if (tgt_zero) begin
      tgt = '0;
    end else if (tgt_sat) begin
      tgt = LEVEL_MAX;
    end else begin
      tgt = quo;
    end
    dec = cfg.release_per_ms * {{(DecW-MsW){1'b0}}, ms_r};
    if (tgt > envelope_level) begin
      envelope_next = tgt;
    end else if (dec >= {{(DecW-WordW){1'b0}}, envelope_level}) begin
      envelope_next = '0;
    end else begin
      envelope_next = envelope_level - dec[WordW-1:0];
    end
  end

  always_comb begin
    floor_sum = {1'b0, prod[2*WordW-1:8]} + {9'b0, cfg.floor_margin};
    if (floor_sum < {9'b0, cfg.floor_lowest}) begin
      floor_next = cfg.floor_lowest;
    end else if (floor_sum > {9'b0, cfg.floor_highest}) begin
      floor_next = cfg.floor_highest;
    end else begin
      floor_next = floor_sum[WordW-1:0];
    end
  end

  assign status.is_clear  = (cmd_r == CMD_CLEAR);
  assign status.is_cal    = (cmd_r == CMD_CALIBRATE);
  assign status.will_full = window_full || (write_index == IdxLast);
  assign status.div_last  = (div_cnt == {DivCntW{1'b1}});
  assign status.scan_last = (scan_cnt == CntEnd);

  always_ff @(posedge clk) begin
    if (cmd_ctl.capture) begin
      cmd_r <= cmd;
      rms_r <= rms_sample;
      ms_r  <= elapsed_ms;
    end
    if (cmd_ctl.load_floor) begin
      fl <= fl_next;
    end
    if (cmd_ctl.prep) begin
      tgt_zero <= (rms_r <= fl) || (cfg.full_scale < fl);
      tgt_sat  <= num[2*WordW-1:WordW] >= den_next;
      rem      <= num[2*WordW-1:WordW];
      quo      <= num[WordW-1:0];
      den      <= den_next;
      div_cnt  <= '0;
    end
    if (cmd_ctl.div_step) begin
      rem     <= rem_ge ? WordW'(rem_shift - {1'b0, den}) : rem_shift[WordW-1:0];
      quo     <= {quo[WordW-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd_ctl.env_step) begin
      scan_cnt <= '0;
      rd_vld   <= 1'b0;
    end
    if (cmd_ctl.scan_step) begin
      rd_vld   <= scan_cnt < CntEnd;
      scan_cnt <= scan_cnt + 1'b1;
      if (rd_vld && ((scan_cnt == CntW'(1)) || (rd_data < win_min))) begin
        win_min <= rd_data;
      end
    end
    if (cmd_ctl.mul) begin
      prod <= win_min * cfg.floor_factor;
    end
    if (cmd_ctl.load_out) begin
      level_out   <= envelope_level;
      floor_out   <= floor_level;
      floor_ready <= window_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ctl.env_step && status.is_cal) begin
      window_store[write_index] <= rms_r;
    end
    if (cmd_ctl.scan_step) begin
      rd_data <= window_store[scan_cnt[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope_level <= '0;
      floor_level    <= FLOOR_LOWEST_RST;
      write_index    <= '0;
      window_full    <= 1'b0;
    end else if (cmd_ctl.clear) begin
      floor_level <= cfg.floor_lowest;
      write_index <= '0;
      window_full <= 1'b0;
    end else begin
      if (cmd_ctl.env_step) begin
        envelope_level <= envelope_next;
        if (status.is_cal) begin
          write_index <= (write_index == IdxLast) ? '0 : write_index + 1'b1;
          window_full <= status.will_full;
          if (!status.will_full) begin
            floor_level <= cfg.floor_lowest;
          end
        end
      end
      if (cmd_ctl.floor_upd) begin
        floor_level <= floor_next;
      end
    end
  end

endmodule

// File: rtl/core/nflf_ctrl.sv
// Controller state machine that sequences the datapath and owns both handshakes.
module nflf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  nflf_pkg::dp_status_t status,
  output nflf_pkg::dp_cmd_t    cmd_ctl
);
  import nflf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_ENV   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_FLOOR = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd_ctl    = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd_ctl.capture = 1'b1;
          state_next      = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status.is_clear) begin
          cmd_ctl.clear = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd_ctl.load_floor = 1'b1;
          state_next         = S_PREP;
        end
      end
      S_PREP: begin
        cmd_ctl.prep = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd_ctl.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_ENV;
        end
      end
      S_ENV: begin
        cmd_ctl.env_step = 1'b1;
        if (status.is_cal && status.will_full) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_ctl.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd_ctl.mul = 1'b1;
        state_next  = S_FLOOR;
      end
      S_FLOOR: begin
        cmd_ctl.floor_upd = 1'b1;
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd_ctl.load_out = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result_valid_next = cmd_ctl.load_out || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule
